// ----- src/rfsm_pkg.sv -----
// Shared types and constants for the record filter subset match unit.
package rfsm_pkg;

    localparam int DATA_TYPE_W    = 16;
    localparam int KEY_W          = DATA_TYPE_W + 1;
    localparam int REC_IDX_W      = 8;
    localparam int FCOUNT_W       = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = KEY_W;
    localparam int MAX_FILTER_DEF = 4;
    localparam int NUM_ENTRY_REGS = 4;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_COUNT  = CFG_IDX_W'(0);
    localparam int                   REG_FILTER_ENTRY0 = 1;

    localparam logic [REC_IDX_W-1:0] REC_IDX_MAX = {REC_IDX_W{1'b1}};

    typedef struct packed {
        logic             entry_valid;
        logic [KEY_W-1:0] key;          // data type in 16..1, role in 0
        logic             record_end;
        logic             list_end;
    } item_t;

    typedef struct packed {
        logic                 match_found;
        logic [REC_IDX_W-1:0] record_index;
    } result_t;

endpackage

// ----- src/rfsm_cfg.sv -----
// Configuration registers: filter count and filter elements.
module rfsm_cfg
    import rfsm_pkg::*;
#(
    parameter int MAX_FILTER = MAX_FILTER_DEF,
    parameter int CNT_W      = $clog2(MAX_FILTER + 1)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]             cfg_addr,
    input  logic [CFG_DATA_W-1:0]            cfg_wdata,
    output logic [CNT_W-1:0]                 active_count,
    output logic [MAX_FILTER-1:0][KEY_W-1:0] filter_entry
);

    logic [FCOUNT_W-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_wr_en && cfg_addr == REG_FILTER_COUNT) begin
            count_reg <= cfg_wdata[FCOUNT_W-1:0];
        end
    end

    // counts above the limit clamp to it
    always_comb begin
        if (count_reg > FCOUNT_W'(MAX_FILTER)) begin
            active_count = CNT_W'(MAX_FILTER);
        end else begin
            active_count = CNT_W'(count_reg);
        end
    end

    for (genvar k = 0; k < MAX_FILTER; k++) begin : g_entry
        if (k < NUM_ENTRY_REGS) begin : g_reg
            logic [KEY_W-1:0] entry_reg;
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    entry_reg <= '0;
                end else if (cfg_wr_en &&
                             cfg_addr == CFG_IDX_W'(REG_FILTER_ENTRY0 + k)) begin
                    entry_reg <= cfg_wdata[KEY_W-1:0];
                end
            end
            assign filter_entry[k] = entry_reg;
        end else begin : g_none
            // no register index reaches this element
            assign filter_entry[k] = '0;
        end
    end

endmodule

// ----- src/rfsm_in_reg.sv -----
// Input register stage: holds one accepted entry transfer.
module rfsm_in_reg
    import rfsm_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  item_t s_item,
    output logic  item_valid,
    output item_t item,
    input  logic  item_pop
);

    logic  valid_reg;
    item_t item_reg;
    logic  take;

    assign s_tready = !valid_reg || item_pop;
    assign take     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= 1'b1;
        end else if (item_pop) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- src/rfsm_core.sv -----
// Match state, per-record mask update and the result register.
module rfsm_core
    import rfsm_pkg::*;
#(
    parameter int MAX_FILTER = MAX_FILTER_DEF,
    parameter int CNT_W      = $clog2(MAX_FILTER + 1)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             item_valid,
    input  item_t                            item,
    output logic                             item_pop,
    input  logic [CNT_W-1:0]                 active_count,
    input  logic [MAX_FILTER-1:0][KEY_W-1:0] filter_entry,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output result_t                          m_result
);

    logic [MAX_FILTER-1:0] mask_reg, mask_next, hit, need;
    logic [REC_IDX_W-1:0]  rec_cnt_reg, rec_cnt_next;
    logic                  seen_reg, seen_next;
    logic [REC_IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic                  out_valid_reg;
    result_t               out_reg, out_next;
    logic                  close_rec, full, seen_now;
    logic [REC_IDX_W-1:0]  idx_now;

    // a list end waits only while an untaken result occupies the output
    assign item_pop = item_valid && (!item.list_end || !out_valid_reg || m_tready);

    always_comb begin
        for (int k = 0; k < MAX_FILTER; k++) begin
            need[k] = CNT_W'(k) < active_count;
            hit[k]  = item.entry_valid && need[k] && (filter_entry[k] == item.key);
        end
    end

    assign mask_next = mask_reg | hit;
    assign full      = &(mask_next | ~need);
    assign close_rec = item.record_end || item.list_end;
    assign seen_now  = seen_reg || (close_rec && full);
    assign idx_now   = seen_reg ? hit_idx_reg : rec_cnt_reg;

    always_comb begin
        if (active_count == '0) begin
            out_next.match_found  = 1'b1;
            out_next.record_index = '0;
        end else begin
            out_next.match_found  = seen_now;
            out_next.record_index = seen_now ? idx_now : '0;
        end
    end

    always_comb begin
        if (item.list_end) begin
            rec_cnt_next = '0;
            seen_next    = 1'b0;
            hit_idx_next = '0;
        end else begin
            rec_cnt_next = rec_cnt_reg;
            if (close_rec && rec_cnt_reg != REC_IDX_MAX) begin
                rec_cnt_next = rec_cnt_reg + REC_IDX_W'(1);
            end
            seen_next    = seen_now;
            hit_idx_next = seen_now ? idx_now : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= '0;
            rec_cnt_reg <= '0;
            seen_reg    <= 1'b0;
            hit_idx_reg <= '0;
        end else if (item_pop) begin
            mask_reg    <= close_rec ? '0 : mask_next;
            rec_cnt_reg <= rec_cnt_next;
            seen_reg    <= seen_next;
            hit_idx_reg <= hit_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (item_pop && item.list_end) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_pop && item.list_end) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;

endmodule

// ----- src/record_filter_subset_match_unit.sv -----
// Top level of the record filter subset match unit.
//
// Endpoint entries arrive on the s_ stream, one transfer per endpoint, records
// back to back; s_tuser[1] closes a record and s_tlast closes the whole list.
// Every active filter element (data type and role) must be covered by some
// endpoint of a record for that record to match. On the list-closing transfer
// one result goes out on the m_ stream: found flag and index of the first
// matching record (0 when none, found with index 0 when the filter is empty).
// Filter count and elements are set through the cfg_ write port; the user must
// write them only while idle, which the block does not enforce. Throughput: one
// entry per cycle unless a list end waits on an untaken result; a list-closing
// transfer passes the input register and compare/mask logic to the result on m_.
// Reset clears the filter registers, match state and both stream stages.
// A stalled m_ side holds the result; entries keep flowing until the next
// list-closing transfer, which waits in the input register and then holds
// s_tready low.
module record_filter_subset_match_unit
    import rfsm_pkg::*;
#(
    parameter int MAX_FILTER = MAX_FILTER_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // [15:0] entry_data_type, [16] entry_role
    input  logic [S_TUSER_W-1:0]  s_tuser,  // [0] entry_valid, [1] record_end
    input  logic                  s_tlast,  // list_end
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata   // [0] match_found, [8:1] record_index
);

    localparam int CNT_W = $clog2(MAX_FILTER + 1);

    logic [CNT_W-1:0]                 active_count;
    logic [MAX_FILTER-1:0][KEY_W-1:0] filter_entry;
    item_t                            s_item, item;
    logic                             item_valid, item_pop;
    result_t                          m_result;

    assign s_item.entry_valid = s_tuser[0];
    assign s_item.key         = {s_tdata[DATA_TYPE_W-1:0], s_tdata[DATA_TYPE_W]};
    assign s_item.record_end  = s_tuser[1];
    assign s_item.list_end    = s_tlast;

    rfsm_cfg #(
        .MAX_FILTER (MAX_FILTER),
        .CNT_W      (CNT_W)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .active_count (active_count),
        .filter_entry (filter_entry)
    );

    rfsm_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    rfsm_core #(
        .MAX_FILTER (MAX_FILTER),
        .CNT_W      (CNT_W)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (item_valid),
        .item         (item),
        .item_pop     (item_pop),
        .active_count (active_count),
        .filter_entry (filter_entry),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_result     (m_result)
    );

    assign m_tdata = M_TDATA_W'({m_result.record_index, m_result.match_found});

endmodule
